// ===== hdl/life_row_generation_step_top_macros.svh =====
// Assertion macros used by the checker of the row generation block.
`ifndef LIFE_ROW_GENERATION_STEP_TOP_MACROS_SVH
`define LIFE_ROW_GENERATION_STEP_TOP_MACROS_SVH

// The consequent is checked in the cycle after the antecedent.
`define LRG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent is checked in the same cycle as the antecedent.
`define LRG_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lrg_pkg.sv =====
// Shared constants and types of the row generation block.
package lrg_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int CELL_W   = 64;
  localparam int ROWNUM_W = 10;
  localparam int POP_W    = 16;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] WIDTH_RST = 7'd64;

  // Neighbor counts of rule B3/S23.
  localparam int BIRTH_N   = 3;
  localparam int SURVIVE_N = 2;

  // Result queue depth; a power of two so the pointers wrap naturally.
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic [CELL_W-1:0]   next_row_cells;
    logic [ROWNUM_W-1:0] row_number;
    logic [POP_W-1:0]    population;
    logic                last;
  } res_t;

  typedef struct packed {
    logic not_empty;
    logic room2;
  } oq_stat_t;

endpackage

// ===== hdl/lrg_evolve.sv =====
// One generation step of a single row with wrapped columns, plus its live cell count.
module lrg_evolve #(
  parameter int COLS = lrg_pkg::MAX_COLS_DEF,
  parameter int CW   = $clog2(COLS + 1)
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] here,
  input  logic [COLS-1:0] below,
  input  logic [CW-1:0]   width,
  output logic [COLS-1:0] next_cells,
  output logic [CW-1:0]   live_cnt
);

  localparam int IDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  logic [IDX_W-1:0] last_idx;

  assign last_idx = IDX_W'(width - CW'(1));

  for (genvar j = 0; j < COLS; j++) begin : g_cell
    logic       aw, ae, hw, he, bw, be;
    logic [3:0] n;

    // West neighbor: column zero wraps to the last column in use.
    if (j == 0) begin : g_w0
      assign aw = above[last_idx];
      assign hw = here[last_idx];
      assign bw = below[last_idx];
    end else begin : g_wn
      assign aw = above[j-1];
      assign hw = here[j-1];
      assign bw = below[j-1];
    end

    // East neighbor: the last column in use wraps to column zero.
    if (j == COLS - 1) begin : g_el
      assign ae = above[0];
      assign he = here[0];
      assign be = below[0];
    end else begin : g_en
      logic at_end;
      assign at_end = (IDX_W'(j) == last_idx);
      assign ae = at_end ? above[0] : above[j+1];
      assign he = at_end ? here[0]  : here[j+1];
      assign be = at_end ? below[0] : below[j+1];
    end

    assign n = 4'(aw) + 4'(above[j]) + 4'(ae) + 4'(hw) + 4'(he)
             + 4'(bw) + 4'(below[j]) + 4'(be);

    assign next_cells[j] = (width > CW'(j)) &&
                           ((n == 4'(lrg_pkg::BIRTH_N)) ||
                            ((n == 4'(lrg_pkg::SURVIVE_N)) && here[j]));
  end

  assign live_cnt = CW'($countones(next_cells));

endmodule

// ===== hdl/lrg_outq.sv =====
// Small result queue that takes up to two results per cycle and gives one.
module lrg_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  logic              push1,
  input  lrg_pkg::res_t     wdata0,
  input  lrg_pkg::res_t     wdata1,
  input  logic              pop,
  output lrg_pkg::res_t     rdata,
  output lrg_pkg::oq_stat_t stat
);

  localparam int PTR_W = $clog2(lrg_pkg::OQ_DEPTH);
  localparam int CNT_W = $clog2(lrg_pkg::OQ_DEPTH + 1);

  lrg_pkg::res_t    mem_r [lrg_pkg::OQ_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] wr_plus1;

  assign wr_plus1 = wr_r + PTR_W'(1);

  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push0) + PTR_W'(push1);
    rd_nxt  = rd_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_r] <= wdata0;
    end
    if (push1) begin
      mem_r[wr_plus1] <= wdata1;
    end
  end

  assign rdata          = mem_r[rd_r];
  assign stat.not_empty = (cnt_r != '0);
  // Room for two is judged without the pop of this cycle, so it never reads out_stall.
  assign stat.room2     = (cnt_r <= CNT_W'(lrg_pkg::OQ_DEPTH - 2));

endmodule

// ===== hdl/life_row_generation_step_top.sv =====
// Streaming Game of Life row generation step with wrapped columns and a population count.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_row_cells, in_is_last_row
//   out     | output    | out_valid/out_stall | out_next_row_cells, out_row_number,
//           |           |                     | out_population, out_last
//   cfg     | input     | cfg_valid/cfg_ready | cfg_width_in_use
//
// An accepted row waits in the input register; both possible results are then computed
// combinationally and written to a four-entry result queue. A row's result is pushed as
// the row below moves on, or at once for a last row, which gives up to two results. One
// row per cycle is sustained; in_stall rises only while the queue has fewer than two free
// entries. Reset is synchronous and empties the pipeline; width returns to 64.
module life_row_generation_step_top #(
  parameter int MAX_COLS = lrg_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lrg_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrg_pkg::CELL_W-1:0]    in_row_cells,
  input  logic                          in_is_last_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lrg_pkg::CELL_W-1:0]    out_next_row_cells,
  output logic [lrg_pkg::ROWNUM_W-1:0]  out_row_number,
  output logic [lrg_pkg::POP_W-1:0]     out_population,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lrg_pkg::CFG_W-1:0]     cfg_width_in_use
);

  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int CNT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [lrg_pkg::CFG_W-1:0] width_r;

  logic                s1_vld_r, s1_vld_nxt;
  logic [MAX_COLS-1:0] s1_row_r;
  logic                s1_last_r;

  logic [MAX_COLS-1:0]       upper_r, upper_nxt;
  logic [MAX_COLS-1:0]       middle_r, middle_nxt;
  logic                      mid_vld_r, mid_vld_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [lrg_pkg::POP_W-1:0] total_r, total_nxt;

  logic [WW-1:0]       w_eff;
  logic [MAX_COLS-1:0] mask;
  logic [MAX_COLS-1:0] up_m, mid_m, row_m, up2;
  logic [MAX_COLS-1:0] e1_cells, e2_cells;
  logic [WW-1:0]       e1_cnt, e2_cnt;

  logic                      in_acc, adv;
  logic [CNT_W-1:0]          cnt_inc, num2;
  logic [lrg_pkg::POP_W:0]   sum1, sum2;
  logic [lrg_pkg::POP_W-1:0] pop1, pop2, total_mid;

  lrg_pkg::res_t     res1, res2, head;
  lrg_pkg::oq_stat_t oq_stat;
  logic              push0, push1, pop;

  // Configuration is always taken; it must be written only while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= lrg_pkg::WIDTH_RST;
    end else if (cfg_valid) begin
      width_r <= cfg_width_in_use;
    end
  end

  // A width of zero or beyond the row storage acts as the full row.
  always_comb begin
    if (width_r == '0 || 32'(width_r) > MAX_COLS) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = WW'(width_r);
    end
    for (int j = 0; j < MAX_COLS; j++) begin
      mask[j] = (w_eff > WW'(j));
    end
  end

  // Input register.
  assign in_stall = s1_vld_r && !oq_stat.room2;
  assign in_acc   = in_valid && !in_stall;
  assign adv      = s1_vld_r && oq_stat.room2;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r  <= in_row_cells[MAX_COLS-1:0];
      s1_last_r <= in_is_last_row;
    end
  end

  // Stored rows are masked at use, so they follow the width in force now.
  assign up_m  = upper_r & mask;
  assign mid_m = middle_r & mask;
  assign row_m = s1_row_r & mask;
  assign up2   = mid_vld_r ? mid_m : '0;

  // Result for the waiting middle row, now that the row below it is here.
  lrg_evolve #(.COLS(MAX_COLS), .CW(WW)) u_evolve_mid (
    .above      (up_m),
    .here       (mid_m),
    .below      (row_m),
    .width      (w_eff),
    .next_cells (e1_cells),
    .live_cnt   (e1_cnt)
  );

  // Result for a bottom row, with an empty row beneath it.
  lrg_evolve #(.COLS(MAX_COLS), .CW(WW)) u_evolve_last (
    .above      (up2),
    .here       (row_m),
    .below      ('0),
    .width      (w_eff),
    .next_cells (e2_cells),
    .live_cnt   (e2_cnt)
  );

  always_comb begin
    cnt_inc   = (cnt_r == CNT_W'(MAX_ROWS - 1)) ? '0 : cnt_r + CNT_W'(1);
    num2      = mid_vld_r ? cnt_inc : cnt_r;

    sum1      = {1'b0, total_r} + (lrg_pkg::POP_W + 1)'(e1_cnt);
    pop1      = sum1[lrg_pkg::POP_W] ? '1 : sum1[lrg_pkg::POP_W-1:0];
    total_mid = mid_vld_r ? pop1 : total_r;
    sum2      = {1'b0, total_mid} + (lrg_pkg::POP_W + 1)'(e2_cnt);
    pop2      = sum2[lrg_pkg::POP_W] ? '1 : sum2[lrg_pkg::POP_W-1:0];

    res1.next_row_cells = lrg_pkg::CELL_W'(e1_cells);
    res1.row_number     = lrg_pkg::ROWNUM_W'(cnt_r);
    res1.population     = pop1;
    res1.last           = 1'b0;

    res2.next_row_cells = lrg_pkg::CELL_W'(e2_cells);
    res2.row_number     = lrg_pkg::ROWNUM_W'(num2);
    res2.population     = pop2;
    res2.last           = 1'b1;

    push0 = adv && (mid_vld_r || s1_last_r);
    push1 = adv && mid_vld_r && s1_last_r;
  end

  // Generation state; a bottom row closes the generation and clears it all.
  always_comb begin
    upper_nxt   = upper_r;
    middle_nxt  = middle_r;
    mid_vld_nxt = mid_vld_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    if (adv) begin
      if (s1_last_r) begin
        upper_nxt   = '0;
        middle_nxt  = '0;
        mid_vld_nxt = 1'b0;
        cnt_nxt     = '0;
        total_nxt   = '0;
      end else begin
        upper_nxt   = up2;
        middle_nxt  = row_m;
        mid_vld_nxt = 1'b1;
        cnt_nxt     = mid_vld_r ? cnt_inc : cnt_r;
        total_nxt   = total_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r   <= '0;
      middle_r  <= '0;
      mid_vld_r <= 1'b0;
      cnt_r     <= '0;
      total_r   <= '0;
    end else begin
      upper_r   <= upper_nxt;
      middle_r  <= middle_nxt;
      mid_vld_r <= mid_vld_nxt;
      cnt_r     <= cnt_nxt;
      total_r   <= total_nxt;
    end
  end

  assign pop = oq_stat.not_empty && !out_stall;

  lrg_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push0  (push0),
    .push1  (push1),
    .wdata0 (mid_vld_r ? res1 : res2),
    .wdata1 (res2),
    .pop    (pop),
    .rdata  (head),
    .stat   (oq_stat)
  );

  assign out_valid          = oq_stat.not_empty;
  assign out_next_row_cells = head.next_row_cells;
  assign out_row_number     = head.row_number;
  assign out_population     = head.population;
  assign out_last           = head.last;

endmodule

// ===== hdl/lrg_checker.sv =====
// Port-level checker of the row generation block and its bind to the top level.
`include "life_row_generation_step_top_macros.svh"

module lrg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [lrg_pkg::CELL_W-1:0]    out_next_row_cells,
  input logic [lrg_pkg::ROWNUM_W-1:0]  out_row_number,
  input logic [lrg_pkg::POP_W-1:0]     out_population,
  input logic                          out_last
);

  lrg_pkg::res_t             out_payload;
  logic                      in_wait, out_wait, gen_end, gen_mid, first_row, pop_up;
  logic [lrg_pkg::POP_W-1:0] pop_prev_r;

  assign out_payload = {out_next_row_cells, out_row_number, out_population, out_last};
  assign in_wait     = in_valid && in_stall;
  assign out_wait    = out_valid && out_stall;
  assign gen_end     = out_valid && !out_stall && out_last;
  assign gen_mid     = out_valid && !out_stall && !out_last;
  assign first_row   = (out_row_number == '0);
  assign pop_up      = (out_population >= pop_prev_r);

  always_ff @(posedge clk) begin
    pop_prev_r <= out_population;
  end

  // A stalled result transaction keeps its payload.
  `LRG_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_payload), "held result changed")

  // The input is held back only while results are waiting to be taken.
  `LRG_ASSERT_SAME(a_stall_cause, in_wait, out_valid, "input stalled with no result pending")

  // The result after a bottom row opens a new generation at row zero.
  `LRG_ASSERT_NEXT(a_new_gen, gen_end, !out_valid || first_row, "generation not at row zero")

  // Within a generation the running population never falls.
  `LRG_ASSERT_NEXT(a_pop_mono, gen_mid, !out_valid || pop_up, "population decreased")

endmodule

bind life_row_generation_step_top lrg_checker u_lrg_checker (.*);
